>>> src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is high
`define MI3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked on every rising edge, reset included
`define MI3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mi3_pkg.sv
// constants, types and index tables for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

   localparam int ELEM_W  = 32;
   localparam int NELEM   = 9;
   localparam int NDIM    = 3;
   localparam int NTERM   = 6;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int PPL_W   = PROD_W + 1;
   localparam int DET_W   = 98;
   localparam int DMAG_W  = 96;
   localparam int COF_W   = 64;
   localparam int FRAC_W  = 32;
   localparam int REM_W   = COF_W + FRAC_W;
   localparam int THR_W   = 31;
   localparam int Q_W     = 33;
   localparam int CMP_W   = DMAG_W + Q_W + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // Sarrus terms: a * b * c, subtracted where TERM_MINUS is set
   localparam int TERM_A [NTERM] = '{0, 6, 1, 7, 2, 8};
   localparam int TERM_B [NTERM] = '{4, 4, 5, 5, 3, 3};
   localparam int TERM_C [NTERM] = '{8, 2, 6, 0, 7, 1};
   localparam bit TERM_MINUS [NTERM] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   // the two rows (or columns) left over when one is struck out
   localparam int OTHER_LO [NDIM] = '{1, 0, 0};
   localparam int OTHER_HI [NDIM] = '{2, 2, 1};

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(SAT_POS);
   localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(SAT_NEG);

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic [NELEM-1:0][COF_W-1:0] cof_mag;
      logic [NELEM-1:0]            cof_neg;
      logic [DMAG_W-1:0]           dmag;
      logic                        dneg;
      logic                        singular;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

>>> src/mi3_req_if.sv
// request channel: one 3x3 matrix with valid/ready
// depends on mi3_pkg
interface mi3_req_if;
   logic valid;
   logic ready;
   mi3_pkg::elem_type in_r0c0;
   mi3_pkg::elem_type in_r0c1;
   mi3_pkg::elem_type in_r0c2;
   mi3_pkg::elem_type in_r1c0;
   mi3_pkg::elem_type in_r1c1;
   mi3_pkg::elem_type in_r1c2;
   mi3_pkg::elem_type in_r2c0;
   mi3_pkg::elem_type in_r2c1;
   mi3_pkg::elem_type in_r2c2;

   modport source (output valid, output in_r0c0, output in_r0c1, output in_r0c2,
                   output in_r1c0, output in_r1c1, output in_r1c2,
                   output in_r2c0, output in_r2c1, output in_r2c2, input ready);
   modport sink (input valid, input in_r0c0, input in_r0c1, input in_r0c2,
                 input in_r1c0, input in_r1c1, input in_r1c2,
                 input in_r2c0, input in_r2c1, input in_r2c2, output ready);
endinterface

>>> src/mi3_rsp_if.sv
// response channel: inverse matrix and flags with valid/ready
// depends on mi3_pkg
interface mi3_rsp_if;
   logic valid;
   logic ready;
   mi3_pkg::elem_type inv_r0c0;
   mi3_pkg::elem_type inv_r0c1;
   mi3_pkg::elem_type inv_r0c2;
   mi3_pkg::elem_type inv_r1c0;
   mi3_pkg::elem_type inv_r1c1;
   mi3_pkg::elem_type inv_r1c2;
   mi3_pkg::elem_type inv_r2c0;
   mi3_pkg::elem_type inv_r2c1;
   mi3_pkg::elem_type inv_r2c2;
   logic singular;
   logic saturated;

   modport source (output valid, output inv_r0c0, output inv_r0c1, output inv_r0c2,
                   output inv_r1c0, output inv_r1c1, output inv_r1c2,
                   output inv_r2c0, output inv_r2c1, output inv_r2c2,
                   output singular, output saturated, input ready);
   modport sink (input valid, input inv_r0c0, input inv_r0c1, input inv_r0c2,
                 input inv_r1c0, input inv_r1c1, input inv_r1c2,
                 input inv_r2c0, input inv_r2c1, input inv_r2c2,
                 input singular, input saturated, output ready);
endinterface

>>> src/matrix3x3_inverse_top.sv
// 3x3 Q16.16 matrix inverse by the adjugate: one matrix accepted per cycle
// unless a full queue stalls it; pipeline of 6 front stages, queue, 34 divider
// stages, output register; one result per cycle while the output is taken
// synchronous active-high reset empties all stages and the queue, threshold
// returns to 1; depends on mi3_pkg, mi3_req_if, mi3_rsp_if, mi3_front/fifo/back
module matrix3x3_inverse_top (
   input  logic                          clock,
   input  logic                          reset,
   mi3_req_if.sink                       req_if,
   mi3_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [mi3_pkg::THR_W-1:0]     csr_wr_data
);

   logic [mi3_pkg::THR_W-1:0] min_abs_det_ff;

   mi3_pkg::elem_type [mi3_pkg::NELEM-1:0] in_mat;
   mi3_pkg::elem_type [mi3_pkg::NELEM-1:0] out_inv;
   mi3_pkg::fifo_stat_type fifo_stat;
   mi3_pkg::job_type push_data, pop_data;
   logic push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_abs_det_ff <= mi3_pkg::THR_W'(1);
      end else if (csr_wr_en) begin
         min_abs_det_ff <= csr_wr_data;
      end
   end

   assign in_mat[0] = req_if.in_r0c0;
   assign in_mat[1] = req_if.in_r0c1;
   assign in_mat[2] = req_if.in_r0c2;
   assign in_mat[3] = req_if.in_r1c0;
   assign in_mat[4] = req_if.in_r1c1;
   assign in_mat[5] = req_if.in_r1c2;
   assign in_mat[6] = req_if.in_r2c0;
   assign in_mat[7] = req_if.in_r2c1;
   assign in_mat[8] = req_if.in_r2c2;

   mi3_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .in_mat      (in_mat),
      .min_abs_det (min_abs_det_ff),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_data   (push_data)
   );

   mi3_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   mi3_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_stat     (fifo_stat),
      .job           (pop_data),
      .pop           (pop),
      .out_valid     (rsp_if.valid),
      .out_ready     (rsp_if.ready),
      .out_inv       (out_inv),
      .out_singular  (rsp_if.singular),
      .out_saturated (rsp_if.saturated)
   );

   assign rsp_if.inv_r0c0 = out_inv[0];
   assign rsp_if.inv_r0c1 = out_inv[1];
   assign rsp_if.inv_r0c2 = out_inv[2];
   assign rsp_if.inv_r1c0 = out_inv[3];
   assign rsp_if.inv_r1c1 = out_inv[4];
   assign rsp_if.inv_r1c2 = out_inv[5];
   assign rsp_if.inv_r2c0 = out_inv[6];
   assign rsp_if.inv_r2c1 = out_inv[7];
   assign rsp_if.inv_r2c2 = out_inv[8];

endmodule

>>> src/mi3_fifo.sv
// short job queue between determinant front end and divider back end
// depends on mi3_pkg
module mi3_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mi3_pkg::job_type      push_data,
   input  logic                  pop,
   output mi3_pkg::job_type      pop_data,
   output mi3_pkg::fifo_stat_type stat
);

   mi3_pkg::job_type mem_ff [mi3_pkg::FIFO_DEPTH];
   logic [mi3_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mi3_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mi3_pkg::FIFO_AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + mi3_pkg::FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + mi3_pkg::FIFO_AW'(1) : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (mi3_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (mi3_pkg::FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == (mi3_pkg::FIFO_AW + 1)'(mi3_pkg::FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

>>> src/mi3_front.sv
// front end: accepts matrices, forms cofactors and exact determinant,
// classifies singular ones; depends on mi3_pkg
module mi3_front (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  mi3_pkg::elem_type [mi3_pkg::NELEM-1:0]      in_mat,
   input  logic [mi3_pkg::THR_W-1:0]                   min_abs_det,
   input  mi3_pkg::fifo_stat_type                      fifo_stat,
   output logic                                        push,
   output mi3_pkg::job_type                            push_data
);

   localparam int P = mi3_pkg::PROD_W;
   localparam int D = mi3_pkg::DET_W;
   localparam int NT = mi3_pkg::NTERM;
   localparam int NE = mi3_pkg::NELEM;

   logic adv;

   // stage 1: 32x32 products
   logic f1_vld_ff;
   logic signed [P-1:0] f1_ab_ff [NT], f1_ab_in [NT];
   mi3_pkg::elem_type   f1_c_ff [NT], f1_c_in [NT];
   logic signed [P-1:0] f1_cp0_ff [NE], f1_cp0_in [NE];
   logic signed [P-1:0] f1_cp1_ff [NE], f1_cp1_in [NE];

   // stage 2: partial products of the 96-bit terms, cofactors
   logic f2_vld_ff;
   logic signed [P-1:0]               f2_pph_ff [NT], f2_pph_in [NT];
   logic signed [mi3_pkg::PPL_W-1:0]  f2_ppl_ff [NT], f2_ppl_in [NT];
   logic [NE-1:0][mi3_pkg::COF_W-1:0] f2_cm_ff, f2_cm_in;
   logic [NE-1:0]                     f2_cn_ff, f2_cn_in;

   // stages 3 to 5: signed terms, pair sums, determinant
   logic f3_vld_ff, f4_vld_ff, f5_vld_ff;
   logic signed [D-1:0] f3_t_ff [NT], f3_t_in [NT];
   logic signed [D-1:0] f4_s_ff [3], f4_s_in [3];
   logic signed [D-1:0] f5_det_ff, f5_det_in;
   logic [NE-1:0][mi3_pkg::COF_W-1:0] f3_cm_ff, f4_cm_ff, f5_cm_ff;
   logic [NE-1:0]                     f3_cn_ff, f4_cn_ff, f5_cn_ff;

   // stage 6: classified job
   logic             f6_vld_ff;
   mi3_pkg::job_type f6_job_ff, f6_job_in;

   assign adv      = !(f6_vld_ff && fifo_stat.full);
   assign in_ready = adv;
   assign push     = f6_vld_ff && adv;
   assign push_data = f6_job_ff;

   always_comb begin
      logic signed [P-1:0] cf;
      logic [D-1:0]        dabs;
      int n;
      for (int k = 0; k < NT; k++) begin
         f1_ab_in[k] = P'($signed(in_mat[mi3_pkg::TERM_A[k]]))
                     * P'($signed(in_mat[mi3_pkg::TERM_B[k]]));
         f1_c_in[k]  = in_mat[mi3_pkg::TERM_C[k]];
      end
      for (int i = 0; i < mi3_pkg::NDIM; i++) begin
         for (int j = 0; j < mi3_pkg::NDIM; j++) begin
            // cofactor of (i, j) lands on the transposed position
            n = j * mi3_pkg::NDIM + i;
            // minor of (i, j): e0 * e3 - e2 * e1
            f1_cp0_in[n] =
               P'($signed(in_mat[mi3_pkg::OTHER_LO[i] * mi3_pkg::NDIM + mi3_pkg::OTHER_LO[j]]))
             * P'($signed(in_mat[mi3_pkg::OTHER_HI[i] * mi3_pkg::NDIM + mi3_pkg::OTHER_HI[j]]));
            f1_cp1_in[n] =
               P'($signed(in_mat[mi3_pkg::OTHER_HI[i] * mi3_pkg::NDIM + mi3_pkg::OTHER_LO[j]]))
             * P'($signed(in_mat[mi3_pkg::OTHER_LO[i] * mi3_pkg::NDIM + mi3_pkg::OTHER_HI[j]]));
         end
      end

      for (int k = 0; k < NT; k++) begin
         f2_pph_in[k] = P'($signed(f1_ab_ff[k][P-1:mi3_pkg::ELEM_W])) * P'(f1_c_ff[k]);
         f2_ppl_in[k] = $signed({1'b0, f1_ab_ff[k][mi3_pkg::ELEM_W-1:0]})
                      * mi3_pkg::PPL_W'(f1_c_ff[k]);
      end
      for (int i = 0; i < mi3_pkg::NDIM; i++) begin
         for (int j = 0; j < mi3_pkg::NDIM; j++) begin
            n = j * mi3_pkg::NDIM + i;
            // 64-bit wrap as in two's complement
            cf = f1_cp0_ff[n] - f1_cp1_ff[n];
            if (((i + j) % 2) == 1) begin
               cf = -cf;
            end
            f2_cn_in[n] = cf[P-1];
            f2_cm_in[n] = cf[P-1] ? mi3_pkg::COF_W'(-cf) : mi3_pkg::COF_W'(cf);
         end
      end

      for (int k = 0; k < NT; k++) begin
         f3_t_in[k] = (D'(f2_pph_ff[k]) <<< mi3_pkg::ELEM_W) + D'(f2_ppl_ff[k]);
         if (mi3_pkg::TERM_MINUS[k]) begin
            f3_t_in[k] = -f3_t_in[k];
         end
      end

      for (int k = 0; k < 3; k++) begin
         f4_s_in[k] = f3_t_ff[2 * k] + f3_t_ff[2 * k + 1];
      end
      f5_det_in = f4_s_ff[0] + f4_s_ff[1] + f4_s_ff[2];

      dabs = f5_det_ff[D-1] ? D'(-f5_det_ff) : D'(f5_det_ff);
      f6_job_in.cof_mag  = f5_cm_ff;
      f6_job_in.cof_neg  = f5_cn_ff;
      f6_job_in.dneg     = f5_det_ff[D-1];
      f6_job_in.dmag     = dabs[mi3_pkg::DMAG_W-1:0];
      // threshold is compared with the magnitude truncated to Q48.16
      f6_job_in.singular = (dabs[mi3_pkg::DMAG_W-1:0] == '0)
         || (dabs[mi3_pkg::DMAG_W-1:mi3_pkg::FRAC_W]
             < (mi3_pkg::DMAG_W - mi3_pkg::FRAC_W)'(min_abs_det));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
         f5_vld_ff <= 1'b0;
         f6_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= in_valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         f4_vld_ff <= f3_vld_ff;
         f5_vld_ff <= f4_vld_ff;
         f6_vld_ff <= f5_vld_ff;
      end
      if (adv) begin
         f1_ab_ff  <= f1_ab_in;
         f1_c_ff   <= f1_c_in;
         f1_cp0_ff <= f1_cp0_in;
         f1_cp1_ff <= f1_cp1_in;
         f2_pph_ff <= f2_pph_in;
         f2_ppl_ff <= f2_ppl_in;
         f2_cm_ff  <= f2_cm_in;
         f2_cn_ff  <= f2_cn_in;
         f3_t_ff   <= f3_t_in;
         f3_cm_ff  <= f2_cm_ff;
         f3_cn_ff  <= f2_cn_ff;
         f4_s_ff   <= f4_s_in;
         f4_cm_ff  <= f3_cm_ff;
         f4_cn_ff  <= f3_cn_ff;
         f5_det_ff <= f5_det_in;
         f5_cm_ff  <= f4_cm_ff;
         f5_cn_ff  <= f4_cn_ff;
         f6_job_ff <= f6_job_in;
      end
   end

endmodule

>>> src/mi3_back.sv
// back end: nine restoring dividers, one quotient bit per stage after the first,
// then rounding toward zero, saturation and output register; depends on mi3_pkg
module mi3_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mi3_pkg::fifo_stat_type                 fifo_stat,
   input  mi3_pkg::job_type                       job,
   output logic                                   pop,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output mi3_pkg::elem_type [mi3_pkg::NELEM-1:0] out_inv,
   output logic                                   out_singular,
   output logic                                   out_saturated
);

   localparam int NE = mi3_pkg::NELEM;
   localparam int QW = mi3_pkg::Q_W;
   localparam int NSTAGE = QW + 1;
   localparam int CW = mi3_pkg::CMP_W;

   logic adv;

   logic                        b_vld_ff  [NSTAGE], b_vld_in  [NSTAGE];
   logic [mi3_pkg::REM_W-1:0]   b_rem_ff  [NSTAGE][NE], b_rem_in [NSTAGE][NE];
   logic [QW-1:0]               b_q_ff    [NSTAGE][NE], b_q_in   [NSTAGE][NE];
   logic                        b_ovf_ff  [NSTAGE][NE], b_ovf_in [NSTAGE][NE];
   logic                        b_neg_ff  [NSTAGE][NE], b_neg_in [NSTAGE][NE];
   logic [mi3_pkg::DMAG_W-1:0]  b_dmag_ff [NSTAGE], b_dmag_in [NSTAGE];
   logic                        b_sing_ff [NSTAGE], b_sing_in [NSTAGE];

   logic                        rsp_vld_ff;
   mi3_pkg::elem_type [NE-1:0]  rsp_inv_ff, rsp_inv_in;
   logic                        rsp_sing_ff, rsp_sing_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   assign adv = !rsp_vld_ff || out_ready;
   assign pop = adv && !fifo_stat.empty;

   always_comb begin
      logic [mi3_pkg::REM_W-1:0] num;
      logic [CW-1:0] rem_w, dsh;
      logic [QW-1:0] q;
      int src;
      b_vld_in[0]  = pop;
      b_dmag_in[0] = job.dmag;
      b_sing_in[0] = job.singular;
      for (int e = 0; e < NE; e++) begin
         num = {job.cof_mag[e], {mi3_pkg::FRAC_W{1'b0}}};
         b_rem_in[0][e] = num;
         b_q_in[0][e]   = '0;
         // quotient too wide for the bit steps below
         b_ovf_in[0][e] = CW'(num) >= (CW'(job.dmag) << QW);
         b_neg_in[0][e] = job.cof_neg[e] ^ job.dneg;
      end

      for (int s = 1; s < NSTAGE; s++) begin
         b_vld_in[s]  = b_vld_ff[s-1];
         b_dmag_in[s] = b_dmag_ff[s-1];
         b_sing_in[s] = b_sing_ff[s-1];
         for (int e = 0; e < NE; e++) begin
            rem_w = CW'(b_rem_ff[s-1][e]);
            dsh   = CW'(b_dmag_ff[s-1]) << (QW - s);
            b_ovf_in[s][e] = b_ovf_ff[s-1][e];
            b_neg_in[s][e] = b_neg_ff[s-1][e];
            if (rem_w >= dsh) begin
               b_rem_in[s][e] = mi3_pkg::REM_W'(rem_w - dsh);
               b_q_in[s][e]   = b_q_ff[s-1][e] | (QW'(1) << (QW - s));
            end else begin
               b_rem_in[s][e] = b_rem_ff[s-1][e];
               b_q_in[s][e]   = b_q_ff[s-1][e];
            end
         end
      end

      src = NSTAGE - 1;
      rsp_sing_in = b_sing_ff[src];
      rsp_sat_in  = 1'b0;
      for (int e = 0; e < NE; e++) begin
         q = b_q_ff[src][e];
         if (b_sing_ff[src]) begin
            rsp_inv_in[e] = '0;
         end else if (b_neg_ff[src][e]) begin
            if (b_ovf_ff[src][e] || (q > mi3_pkg::Q_NEG_LIM)) begin
               rsp_inv_in[e] = mi3_pkg::SAT_NEG;
               rsp_sat_in    = 1'b1;
            end else begin
               rsp_inv_in[e] = (~q[mi3_pkg::ELEM_W-1:0]) + mi3_pkg::ELEM_W'(1);
            end
         end else begin
            if (b_ovf_ff[src][e] || (q > mi3_pkg::Q_POS_LIM)) begin
               rsp_inv_in[e] = mi3_pkg::SAT_POS;
               rsp_sat_in    = 1'b1;
            end else begin
               rsp_inv_in[e] = q[mi3_pkg::ELEM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTAGE; s++) begin
            b_vld_ff[s] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= b_vld_ff[NSTAGE-1];
      end
      if (adv) begin
         b_rem_ff    <= b_rem_in;
         b_q_ff      <= b_q_in;
         b_ovf_ff    <= b_ovf_in;
         b_neg_ff    <= b_neg_in;
         b_dmag_ff   <= b_dmag_in;
         b_sing_ff   <= b_sing_in;
         rsp_inv_ff  <= rsp_inv_in;
         rsp_sing_ff <= rsp_sing_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign out_valid     = rsp_vld_ff;
   assign out_inv       = rsp_inv_ff;
   assign out_singular  = rsp_sing_ff;
   assign out_saturated = rsp_sat_ff;

endmodule

>>> src/mi3_checker.sv
// port-level checks for the matrix inverse top, attached by bind
// depends on assert_macros.svh and matrix3x3_inverse_top
`include "assert_macros.svh"

module mi3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] inv_r0c0,
   input logic [31:0] inv_r0c1,
   input logic [31:0] inv_r0c2,
   input logic [31:0] inv_r1c0,
   input logic [31:0] inv_r1c1,
   input logic [31:0] inv_r1c2,
   input logic [31:0] inv_r2c0,
   input logic [31:0] inv_r2c1,
   input logic [31:0] inv_r2c2,
   input logic        singular,
   input logic        saturated
);

   logic [287:0] inv_all;
   logic [289:0] rsp_payload;
   logic         stalled;
   logic         sing_bad;

   assign inv_all = {inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
                     inv_r2c0, inv_r2c1, inv_r2c2};
   assign rsp_payload = {inv_all, singular, saturated};
   assign stalled  = rsp_valid && !rsp_ready;
   // a singular result carries zeros only
   assign sing_bad = rsp_valid && singular && ((inv_all != '0) || saturated);

   `MI3_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "response valid after reset")
   `MI3_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready, "request not ready after reset")
   `MI3_ASSERT(a_rsp_hold, clock, reset, stalled |=> rsp_valid && $stable(rsp_payload), "stalled response changed")
   `MI3_ASSERT(a_singular_zero, clock, reset, !sing_bad, "singular response not zero")

endmodule

bind matrix3x3_inverse_top mi3_checker u_mi3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .inv_r0c0  (rsp_if.inv_r0c0),
   .inv_r0c1  (rsp_if.inv_r0c1),
   .inv_r0c2  (rsp_if.inv_r0c2),
   .inv_r1c0  (rsp_if.inv_r1c0),
   .inv_r1c1  (rsp_if.inv_r1c1),
   .inv_r1c2  (rsp_if.inv_r1c2),
   .inv_r2c0  (rsp_if.inv_r2c0),
   .inv_r2c1  (rsp_if.inv_r2c1),
   .inv_r2c2  (rsp_if.inv_r2c2),
   .singular  (rsp_if.singular),
   .saturated (rsp_if.saturated)
);

>>> tb/matrix3x3_inverse_top_tb.sv
// self-checking testbench for the 3x3 Q16.16 matrix inverse: random and corner
// matrices against a bit-exact adjugate predictor, with random back-pressure
// depends on mi3_pkg, mi3_req_if, mi3_rsp_if and matrix3x3_inverse_top
module matrix3x3_inverse_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     LIMIT_CYCLES = 1_000_000;
   localparam int     DRAIN_CYCLES = 80;
   localparam int     ONE          = 32'h0001_0000;
   localparam logic [mi3_pkg::THR_W-1:0] THR_MAX = '1;

   typedef logic [mi3_pkg::NELEM-1:0][mi3_pkg::ELEM_W-1:0] matrix_type;
   typedef struct packed {
      matrix_type inv;
      logic       singular;
      logic       saturated;
   } inverse_type;

   typedef enum int {GEN_FULL, GEN_SMALL, GEN_INTEGER, GEN_DEPENDENT, GEN_TINY, GEN_MIXED}
      gen_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [mi3_pkg::THR_W-1:0] csr_wr_data = '0;

   mi3_req_if req ();
   mi3_rsp_if rsp ();

   matrix3x3_inverse_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   matrix_type     pending_matrices[$];
   inverse_type    expected_inverses[$];
   logic [mi3_pkg::THR_W-1:0] threshold = mi3_pkg::THR_W'(1);
   int             errors = 0;
   int             cycles = 0;
   int             send_gap = 0;
   int             hold_left = 0;
   bit             long_hold_req = 0;
   bit             burst = 0;

   // exact adjugate inverse, all arithmetic in 128-bit integers
   function automatic inverse_type inverse_of(matrix_type m,
                                              logic [mi3_pkg::THR_W-1:0] thr);
      logic signed [127:0] e[mi3_pkg::NELEM];
      logic signed [127:0] det, cf;
      logic [127:0]        dmag, num, q;
      logic                dneg, neg;
      inverse_type         res;
      int                  rl, rh, cl, ch;
      for (int k = 0; k < mi3_pkg::NELEM; k++) e[k] = $signed(m[k]);
      det = e[0]*e[4]*e[8] - e[6]*e[4]*e[2] + e[1]*e[5]*e[6]
          - e[7]*e[5]*e[0] + e[2]*e[3]*e[7] - e[8]*e[3]*e[1];
      dneg = det < 0;
      dmag = dneg ? -det : det;
      res = '0;
      res.singular = (dmag == 0) || (dmag[127:96] == 0 && dmag[95:32] < 64'(thr));
      if (res.singular) return res;
      for (int r = 0; r < mi3_pkg::NDIM; r++) begin
         for (int c = 0; c < mi3_pkg::NDIM; c++) begin
            // cofactor of the transposed position: strike row c and column r
            rl = (c == 0) ? 1 : 0;
            rh = (c == 2) ? 1 : 2;
            cl = (r == 0) ? 1 : 0;
            ch = (r == 2) ? 1 : 2;
            cf = e[rl*3+cl]*e[rh*3+ch] - e[rh*3+cl]*e[rl*3+ch];
            if ((r + c) % 2 == 1) cf = -cf;
            num = (cf < 0 ? -cf : cf) << 32;
            q = num / dmag;
            neg = (cf < 0) != dneg;
            if (neg) begin
               if (q > 128'h8000_0000) begin
                  res.saturated = 1'b1;
                  res.inv[r*3+c] = mi3_pkg::SAT_NEG;
               end else begin
                  res.inv[r*3+c] = -q[31:0];
               end
            end else begin
               if (q > 128'h7fff_ffff) begin
                  res.saturated = 1'b1;
                  res.inv[r*3+c] = mi3_pkg::SAT_POS;
               end else begin
                  res.inv[r*3+c] = q[31:0];
               end
            end
         end
      end
      return res;
   endfunction

   function automatic logic [mi3_pkg::ELEM_W-1:0] spread(int half);
      return mi3_pkg::ELEM_W'($urandom_range(0, 2 * half) - half);
   endfunction

   function automatic matrix_type random_matrix(gen_kind_type kind);
      matrix_type m;
      for (int k = 0; k < mi3_pkg::NELEM; k++) begin
         case (kind)
            GEN_FULL:    m[k] = $urandom;
            GEN_SMALL:   m[k] = spread(1 << 18);
            GEN_INTEGER: m[k] = spread(8) << 16;
            GEN_TINY:    m[k] = spread(512);
            default:     m[k] = spread(1 << $urandom_range(4, 30));
         endcase
      end
      if (kind == GEN_DEPENDENT) begin
         for (int k = 0; k < 6; k++) m[k] = spread(1 << 18);
         // third row is the sum of the others, sometimes nudged off singular
         for (int k = 0; k < 3; k++)
            m[6+k] = m[k] + m[3+k] + (($urandom_range(0, 3) == 0) ? spread(4) : '0);
      end
      return m;
   endfunction

   function automatic gen_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return GEN_FULL;
      if (r < 40) return GEN_SMALL;
      if (r < 55) return GEN_INTEGER;
      if (r < 70) return GEN_DEPENDENT;
      if (r < 80) return GEN_TINY;
      return GEN_MIXED;
   endfunction

   function automatic matrix_type diag(logic [mi3_pkg::ELEM_W-1:0] a,
                                       logic [mi3_pkg::ELEM_W-1:0] b,
                                       logic [mi3_pkg::ELEM_W-1:0] c);
      matrix_type m;
      m = '0;
      m[0] = a;
      m[4] = b;
      m[8] = c;
      return m;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req.valid <= 1'b0;
      end else if (pending_matrices.size() > 0) begin
         req.valid   <= 1'b1;
         req.in_r0c0 <= pending_matrices[0][0];
         req.in_r0c1 <= pending_matrices[0][1];
         req.in_r0c2 <= pending_matrices[0][2];
         req.in_r1c0 <= pending_matrices[0][3];
         req.in_r1c1 <= pending_matrices[0][4];
         req.in_r1c2 <= pending_matrices[0][5];
         req.in_r2c0 <= pending_matrices[0][6];
         req.in_r2c1 <= pending_matrices[0][7];
         req.in_r2c2 <= pending_matrices[0][8];
      end else begin
         req.valid <= 1'b0;
      end
   end

   initial begin
      req.valid = 1'b0;
      {req.in_r0c0, req.in_r0c1, req.in_r0c2, req.in_r1c0, req.in_r1c1,
       req.in_r1c2, req.in_r2c0, req.in_r2c1, req.in_r2c2} = '0;
      rsp.ready = 1'b0;
   end

   // request acceptance: predict and pick the next gap
   always @(posedge clock) begin
      if (csr_wr_en) threshold <= csr_wr_data;
      if (!reset && req.valid && req.ready) begin
         expected_inverses.push_back(inverse_of(pending_matrices.pop_front(), threshold));
         if ($urandom_range(0, 63) == 0) burst <= ~burst;
         if (burst || $urandom_range(0, 9) < 6) send_gap <= 0;
         else if ($urandom_range(0, 9) < 8) send_gap <= $urandom_range(1, 3);
         else send_gap <= $urandom_range(10, 40);
      end
   end

   // response ready, with random stalls and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req <= 0;
         hold_left <= 400;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (burst || $urandom_range(0, 9) < 7) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= 1'b0;
         hold_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                 : $urandom_range(10, 40);
      end
   end

   // response monitor
   always @(posedge clock) begin
      inverse_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.inv = {rsp.inv_r2c2, rsp.inv_r2c1, rsp.inv_r2c0, rsp.inv_r1c2, rsp.inv_r1c1,
                    rsp.inv_r1c0, rsp.inv_r0c2, rsp.inv_r0c1, rsp.inv_r0c0};
         got.singular  = rsp.singular;
         got.saturated = rsp.saturated;
         if (expected_inverses.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_inverses.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  for (int k = 0; k < mi3_pkg::NELEM; k++)
                     if (got.inv[k] !== want.inv[k])
                        $display("inv[%0d]: expected %h, got %h", k, want.inv[k], got.inv[k]);
                  if (got.singular !== want.singular || got.saturated !== want.saturated)
                     $display("flags singular/saturated: expected %b%b, got %b%b",
                              want.singular, want.saturated, got.singular, got.saturated);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic drain();
      while (pending_matrices.size() > 0 || expected_inverses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [mi3_pkg::THR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random(int count);
      for (int n = 0; n < count; n++) pending_matrices.push_back(random_matrix(pick_kind()));
   endtask

   initial begin
      matrix_type m;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner matrices at the reset threshold
      pending_matrices.push_back('0);
      pending_matrices.push_back(diag(ONE, ONE, ONE));
      pending_matrices.push_back(diag(-ONE, -ONE, -ONE));
      pending_matrices.push_back(diag(mi3_pkg::SAT_POS, mi3_pkg::SAT_POS, mi3_pkg::SAT_POS));
      pending_matrices.push_back(diag(mi3_pkg::SAT_NEG, mi3_pkg::SAT_NEG, mi3_pkg::SAT_NEG));
      pending_matrices.push_back(diag(32'h8000, 32'h8000, 32'h8000));
      pending_matrices.push_back(diag(32'd1, 32'd1, 32'd1));
      pending_matrices.push_back({mi3_pkg::NELEM{32'hffff_ffff}});
      pending_matrices.push_back({mi3_pkg::NELEM{32'h5555_5555}});
      pending_matrices.push_back({mi3_pkg::NELEM{32'haaaa_aaaa}});
      m = '0;
      m[1] = ONE; m[5] = -ONE; m[6] = 2 * ONE;
      pending_matrices.push_back(m);
      pending_matrices.push_back(random_matrix(GEN_DEPENDENT));
      queue_random(600);
      drain();

      // zero threshold: tiny non-zero determinants saturate
      write_threshold('0);
      pending_matrices.push_back('0);
      pending_matrices.push_back(diag(32'h10, 32'h10, 32'h10));
      pending_matrices.push_back(diag(-32'h10, 32'h10, 32'h10));
      pending_matrices.push_back(diag(32'd1, 32'd1, 32'd1));
      pending_matrices.push_back(diag(mi3_pkg::SAT_NEG, mi3_pkg::SAT_POS, 32'd1));
      queue_random(500);
      drain();

      write_threshold(THR_MAX);
      pending_matrices.push_back(diag(mi3_pkg::SAT_POS, mi3_pkg::SAT_POS, mi3_pkg::SAT_POS));
      queue_random(300);
      drain();

      // one unit of determinant, with the receiver held off while requests pile up
      write_threshold(mi3_pkg::THR_W'(ONE));
      queue_random(300);
      repeat (20) @(posedge clock);
      long_hold_req <= 1;
      drain();

      write_threshold(mi3_pkg::THR_W'($urandom_range(0, 1 << 20)));
      queue_random(200);
      drain();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
